>>> design/mtpe_pkg.sv
package mtpe_pkg;

    localparam int MTPE_WORD_BITS = 32;
    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 2;

    // request types
    localparam logic [1:0] REQ_RESTART = 2'd0;
    localparam logic [1:0] REQ_FILL    = 2'd1;
    localparam logic [1:0] REQ_VERIFY  = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_FINISHED = 2'd2;
    localparam logic [1:0] ST_RESTART  = 2'd3;

    // pattern modes
    localparam logic [2:0] MODE_ADDR  = 3'd0;
    localparam logic [2:0] MODE_A5    = 3'd1;
    localparam logic [2:0] MODE_5A    = 3'd2;
    localparam logic [2:0] MODE_DB6C  = 3'd3;
    localparam logic [2:0] MODE_WALK1 = 3'd4;
    localparam logic [2:0] MODE_WALK0 = 3'd5;
    localparam logic [2:0] MODE_ZERO  = 3'd6;
    localparam logic [2:0] MODE_INCR  = 3'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK  = 2'd3;

    localparam logic [63:0] CHECK_A5   = 64'hA5A5_A5A5_A5A5_A5A5;
    localparam logic [63:0] CHECK_5A   = 64'h5A5A_5A5A_5A5A_5A5A;
    localparam logic [63:0] CHECK_DB6C = 64'hDB6C_DB6C_DB6C_DB6C;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [DATA_W-1:0] read_data;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] word_address;
        logic [DATA_W-1:0] pattern_data;
        logic [1:0]        status;
        logic              last;
    } rsp_t;

    typedef struct packed {
        logic [2:0]        pattern_mode;
        logic [ADDR_W-1:0] start_address;
        logic [ADDR_W-1:0] end_address;
        logic [DATA_W-1:0] compare_mask;
    } cfg_t;

endpackage

>>> design/mtpe_cfg_regs.sv
module mtpe_cfg_regs
    import mtpe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:  cfg_next.pattern_mode  = cfg_wdata[2:0];
                REG_START: cfg_next.start_address = cfg_wdata;
                REG_END:   cfg_next.end_address   = cfg_wdata;
                REG_MASK:  cfg_next.compare_mask  = cfg_wdata;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_mode  <= MODE_ADDR;
            cfg_reg.start_address <= '0;
            cfg_reg.end_address   <= '0;
            cfg_reg.compare_mask  <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/mtpe_seq.sv
module mtpe_seq
    import mtpe_pkg::*;
#(
    parameter int WORD_BITS = MTPE_WORD_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic step,
    input  req_t req,
    output logic has_rsp,
    output rsp_t rsp
);

    localparam int STEP_BYTES = (WORD_BITS + 7) / 8;
    localparam logic [63:0] DATA_MASK64 = {64{1'b1}} >> (64 - WORD_BITS);
    localparam logic [DATA_W-1:0] CMP_MASK = DATA_MASK64[DATA_W-1:0];
    localparam logic [WORD_BITS-1:0] WALK0_SEED = ~WORD_BITS'(1);

    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [WORD_BITS-1:0] pat_reg, pat_next;
    logic                 done_reg, done_next;

    logic [WORD_BITS-1:0] seed;
    logic [WORD_BITS-1:0] pat_adv;
    logic [WORD_BITS-1:0] shl;
    logic [WORD_BITS-1:0] exp_cur;
    logic [WORD_BITS-1:0] exp_rst;
    logic [63:0]          exp_cur_w, exp_rst_w;
    logic [ADDR_W-1:0]    addr_inc;
    logic                 is_last;
    logic                 miss;

    always_comb begin
        case (cfg.pattern_mode)
            MODE_A5:    seed = CHECK_A5[WORD_BITS-1:0];
            MODE_5A:    seed = CHECK_5A[WORD_BITS-1:0];
            MODE_DB6C:  seed = CHECK_DB6C[WORD_BITS-1:0];
            MODE_WALK1: seed = WORD_BITS'(1);
            MODE_WALK0: seed = WALK0_SEED;
            default:    seed = '0;
        endcase
    end

    assign shl = pat_reg << 1;

    always_comb begin
        case (cfg.pattern_mode)
            MODE_A5, MODE_5A, MODE_DB6C: pat_adv = ~pat_reg;
            MODE_WALK1: pat_adv = (shl == '0) ? WORD_BITS'(1) : shl;
            MODE_WALK0: pat_adv = ((shl | WORD_BITS'(1)) == '1) ? WALK0_SEED
                                                                 : (shl | WORD_BITS'(1));
            MODE_INCR:  pat_adv = pat_reg + WORD_BITS'(1);
            MODE_ZERO:  pat_adv = '0;
            default:    pat_adv = pat_reg;
        endcase
    end

    // address mode shows the word's own address, cut to the word width
    assign exp_cur = (cfg.pattern_mode == MODE_ADDR) ? WORD_BITS'({32'd0, addr_reg}) : pat_reg;
    assign exp_rst = (cfg.pattern_mode == MODE_ADDR) ? WORD_BITS'({32'd0, cfg.start_address})
                                                     : seed;
    assign exp_cur_w = 64'(exp_cur);
    assign exp_rst_w = 64'(exp_rst);

    assign addr_inc = addr_reg + ADDR_W'(STEP_BYTES);
    assign is_last  = (addr_inc < addr_reg) || !(addr_inc < cfg.end_address);
    assign miss     = (req.req_type == REQ_VERIFY) &&
                      (((req.read_data ^ exp_cur_w[DATA_W-1:0]) & cfg.compare_mask
                        & CMP_MASK) != '0);

    assign has_rsp = (req.req_type != REQ_NONE);

    always_comb begin
        addr_next = addr_reg;
        pat_next  = pat_reg;
        done_next = done_reg;
        rsp.word_address = addr_reg;
        rsp.pattern_data = '0;
        rsp.status       = ST_FINISHED;
        rsp.last         = 1'b0;
        case (req.req_type)
            REQ_RESTART: begin
                addr_next = cfg.start_address;
                pat_next  = seed;
                done_next = !(cfg.start_address < cfg.end_address);
                rsp.word_address = cfg.start_address;
                rsp.pattern_data = exp_rst_w[DATA_W-1:0];
                rsp.status       = ST_RESTART;
            end
            REQ_FILL, REQ_VERIFY: begin
                if (!done_reg) begin
                    addr_next = addr_inc;
                    pat_next  = pat_adv;
                    done_next = is_last;
                    rsp.pattern_data = exp_cur_w[DATA_W-1:0];
                    rsp.status       = miss ? ST_MISMATCH : ST_OK;
                    rsp.last         = is_last;
                end
            end
            default: begin
                addr_next = addr_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
            pat_reg  <= '0;
            done_reg <= 1'b1;
        end else if (step) begin
            addr_reg <= addr_next;
            pat_reg  <= pat_next;
            done_reg <= done_next;
        end
    end

endmodule

>>> design/memory_test_pattern_engine_top.sv
// An accepted request moves from the request register to the result register once the
// latter is empty or drains (two register stages: request register, then result register).
// Throughput: one request per cycle while m_ready is high (single-pass sequence logic).
// Reset (aresetn, synchronous, active low): registers to their defaults, sequence
// rewound to address 0 with the range marked finished, both pipeline stages empty.
module memory_test_pattern_engine_top
    import mtpe_pkg::*;
#(
    parameter int WORD_BITS = MTPE_WORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  req_t                 s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output rsp_t                 m_data
);

    cfg_t cfg;

    // request stage
    logic in_valid_reg, in_valid_next;
    req_t in_req_reg;

    // result stage
    logic out_valid_reg, out_valid_next;
    rsp_t out_rsp_reg;

    logic step;
    logic has_rsp;
    rsp_t rsp;

    mtpe_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mtpe_seq #(
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .req     (in_req_reg),
        .has_rsp (has_rsp),
        .rsp     (rsp)
    );

    // A held request moves on when the result register is empty or being drained
    // in the same cycle. The sequence state updates on that same edge.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    // type 3 requests are consumed without a result
    always_comb begin
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = has_rsp;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= s_data;
        end
        if (step && has_rsp) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_rsp_reg;

endmodule
